FILE: rtl/lis_pkg.sv
// Shared constants and the token type passed along the tail cell chain.
package lis_pkg;

  // Table depth, value width and result width
  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 16;
  localparam int COUNT_WIDTH = 11;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // One sequence element on its way down the chain
  typedef struct packed {
    logic                          vld;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          eos;
    logic                          done;
    logic [COUNT_WIDTH-1:0]        count;
  } token_t;

endpackage

FILE: rtl/lis_cell.sv
// One tail cell: holds one table entry and forwards the passing token.
module lis_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  lis_pkg::token_t tok_in,
  output lis_pkg::token_t tok_out
);
  import lis_pkg::*;

  logic [VALUE_WIDTH-1:0] tail;
  logic                   filled;
  logic                   filled_next;
  logic                   hit;
  token_t                 tok_next;

  // Claim this cell when it is empty or its tail is not below the value
  assign hit = tok_in.vld && !tok_in.done &&
               (!filled || ($signed(tail) >= $signed(tok_in.value)));

  // Resolve the token here, then let a final token count and clear the cell
  always_comb begin
    tok_next    = tok_in;
    filled_next = filled;
    if (hit) begin
      tok_next.done = 1'b1;
      filled_next   = 1'b1;
    end
    if (tok_in.vld && tok_in.eos) begin
      if (filled_next && (tok_next.count != COUNT_MAX)) begin
        tok_next.count = COUNT_WIDTH'(tok_next.count + 1'b1);
      end
      filled_next = 1'b0;
    end
  end

  // Hold the token for the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

  // Track whether this entry is part of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (advance) begin
      filled <= filled_next;
    end
  end

  // Store the new tail value
  always_ff @(posedge clk) begin
    if (advance && hit) begin
      tail <= tok_in.value;
    end
  end

endmodule

FILE: rtl/lis_out.sv
// Result stage: sticky overflow tracking and the output word register.
module lis_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  lis_pkg::token_t               tok_in,
  output logic                          out_valid,
  output logic [lis_pkg::COUNT_WIDTH-1:0] run_length,
  output logic                          capacity_overflow
);
  import lis_pkg::*;

  logic overflow_seen;
  logic dropped;

  // A token that leaves the chain unresolved found the table full
  assign dropped = tok_in.vld && !tok_in.done;

  // Collect overflow per sequence, clear on the final word
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (advance && tok_in.vld) begin
      overflow_seen <= tok_in.eos ? 1'b0 : (overflow_seen | dropped);
    end
  end

  // Load a result word for each final token
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tok_in.vld && tok_in.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in.vld && tok_in.eos) begin
      run_length        <= tok_in.count;
      capacity_overflow <= overflow_seen | dropped;
    end
  end

endmodule

FILE: rtl/longest_increasing_subsequence_length.sv
// Streaming strict LIS length: 1024 tail cells, one word per cycle unless stalled.
// Each input word becomes a token that walks the row of tail cells, one cell per cycle
// while the row moves, and claims the first empty cell or the first cell whose tail is
// not below it; tokens follow each other in consecutive cycles, so the block takes one
// word every cycle unless a waiting result holds the row. A word flagged end_of_sequence
// counts the filled cells as it passes and empties them, so the next sequence may start
// in the very next cycle. Its result passes through the cell registers of the row and
// then the output register. While a result waits at the output, the whole row holds and
// no input word is taken. No clearing pass is needed after reset.
module longest_increasing_subsequence_length (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              sample_value,
  input  logic                            end_of_sequence,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lis_pkg::COUNT_WIDTH-1:0] run_length,
  output logic                            capacity_overflow
);
  import lis_pkg::*;

  token_t tok [TABLE_DEPTH+1];
  logic   advance;

  // Move the whole row unless a result is waiting
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Form the entering token
  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = in_valid;
    tok[0].value = sample_value[VALUE_WIDTH-1:0];
    tok[0].eos   = end_of_sequence;
  end

  // Row of tail cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lis_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  lis_out u_out (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .tok_in            (tok[TABLE_DEPTH]),
    .out_valid         (out_valid),
    .run_length        (run_length),
    .capacity_overflow (capacity_overflow)
  );

endmodule

FILE: rtl/lis_checker.sv
// Port-level checks for the LIS length block and their binding.
module lis_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lis_pkg::COUNT_WIDTH-1:0] run_length,
  input logic                            capacity_overflow
);
  import lis_pkg::*;

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_length) &&
                                $stable(capacity_overflow))
    else $error("result word changed while stalled");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // A waiting result stops intake
  a_stall_intake: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // Every sequence has at least one element and fits the table
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_length != '0) &&
                  (run_length <= COUNT_WIDTH'(TABLE_DEPTH)))
    else $error("run length out of range");

  // Overflow only with a full table
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && capacity_overflow |-> run_length == COUNT_WIDTH'(TABLE_DEPTH))
    else $error("overflow reported with table not full");

endmodule

bind longest_increasing_subsequence_length lis_checker u_lis_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .run_length        (run_length),
  .capacity_overflow (capacity_overflow)
);

FILE: test/testbench.sv
// Self-checking testbench for the streaming longest increasing subsequence length block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lis_pkg::*;

  localparam int RUN_CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int IDLE_PERCENT    = 17;
  localparam int RANDOM_WORDS    = 500;

  // Value patterns used to build random sequences
  typedef enum int {
    PAT_ANY,
    PAT_NARROW,
    PAT_RISING,
    PAT_FALLING,
    PAT_CORNERS
  } value_pattern_e;

  typedef struct {
    logic [COUNT_WIDTH-1:0] length;
    logic                   overflow;
  } lis_result_t;

  // Patience-sorting tail table and the lengths it is due to report
  class lis_scoreboard;
    logic signed [VALUE_WIDTH-1:0] tails [TABLE_DEPTH];
    int unsigned                   filled;
    bit                            dropped;
    lis_result_t                   due_q [$];
    int                            errors;

    function new();
      filled  = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    // Place an accepted word in the table; close the sequence on its last word
    function void note_word(logic signed [VALUE_WIDTH-1:0] v, logic last);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lis_result_t res;
      lo = 0;
      hi = filled;
      // find the first tail that is not below the value
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (tails[mid] < v) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      if (lo < filled) begin
        tails[lo] = v;
      end else if (filled < TABLE_DEPTH) begin
        tails[filled] = v;
        filled++;
      end else begin
        dropped = 1;
      end
      if (last) begin
        res.length   = (filled > COUNT_MAX) ? COUNT_MAX : filled[COUNT_WIDTH-1:0];
        res.overflow = dropped;
        due_q = {due_q, res};
        filled  = 0;
        dropped = 0;
      end
    endfunction

    // Compare an accepted result word with the oldest length due
    function void check_result(logic [COUNT_WIDTH-1:0] length, logic overflow);
      lis_result_t res;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: run_length=%0d capacity_overflow=%0b", length, overflow);
        return;
      end
      res = due_q.pop_front();
      if (length !== res.length || overflow !== res.overflow) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: run_length exp %0d got %0d, capacity_overflow exp %0b got %0b",
                   res.length, length, res.overflow, overflow);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] sample_value = '0;
  logic                          end_of_sequence = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [COUNT_WIDTH-1:0]        run_length;
  logic                          capacity_overflow;

  lis_scoreboard lis_board = new();
  bit            sender_idles = 1'b1;
  int            results_taken = 0;
  int            cycle_count = 0;

  longest_increasing_subsequence_length u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample_value     (sample_value),
    .end_of_sequence  (end_of_sequence),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .run_length       (run_length),
    .capacity_overflow(capacity_overflow)
  );

  always #2 clk = ~clk;

  // Abort a run that goes past the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one word, after random idle cycles if sender_idles is set; hold it until taken
  task automatic send_word(input logic signed [VALUE_WIDTH-1:0] v, input logic last);
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    sample_value    <= v;
    end_of_sequence <= last;
    do @(posedge clk); while (!in_ready);
    lis_board.note_word(v, last);
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value(
    value_pattern_e pat, logic signed [VALUE_WIDTH-1:0] prev);
    logic signed [VALUE_WIDTH-1:0] v;
    case (pat)
      PAT_NARROW:  v = VALUE_WIDTH'(int'($urandom_range(8)) - 4);
      PAT_RISING:  v = prev + VALUE_WIDTH'($urandom_range(3));
      PAT_FALLING: v = prev - VALUE_WIDTH'($urandom_range(3));
      PAT_CORNERS: begin
        case ($urandom_range(3))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = -16'sd1;
          default: v = '0;
        endcase
      end
      default:     v = VALUE_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  // Take results, idle at random, and once hold off long enough to back up the row
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        lis_board.check_result(run_length, capacity_overflow);
        results_taken++;
      end
      if (!held && results_taken >= 3) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_taken >= 12 && results_taken < 30) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Main stimulus
  initial begin
    int                            words;
    int                            seq_len;
    value_pattern_e                pat;
    logic signed [VALUE_WIDTH-1:0] v;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-word sequences at both extremes
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7fff, 1'b1);
    // equal values count once
    send_word(16'sd5, 1'b0);
    send_word(16'sd5, 1'b0);
    send_word(16'sd5, 1'b1);
    // strictly rising across the full range
    send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh7fff, 1'b1);
    // falling run keeps replacing the first tail
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sh8000, 1'b1);
    // mixed run with a replacement in the middle of the table
    send_word(16'sd10, 1'b0);
    send_word(16'sd30, 1'b0);
    send_word(16'sd20, 1'b0);
    send_word(16'sd40, 1'b0);
    send_word(16'sd25, 1'b0);
    send_word(16'sd50, 1'b1);

    // random sequences, with a stretch where the sender never idles
    words = 0;
    while (words < RANDOM_WORDS) begin
      sender_idles = !(words >= 100 && words < 250);
      seq_len = ($urandom_range(9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 60);
      pat     = value_pattern_e'($urandom_range(4));
      v       = VALUE_WIDTH'($urandom);
      for (int i = 0; i < seq_len; i++) begin
        v = pick_value(pat, v);
        send_word(v, i == seq_len - 1);
        words++;
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (lis_board.pending() != 0)
      @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);

    if (lis_board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
